### sv/fde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fde_pkg
// Shared types, constants and microcode encodings for the feedback delay echo.
// ----------------------------------------------------------------------------
package fde_pkg;

    localparam int DELAY_DEPTH = 131072;
    localparam int ADDR_W      = $clog2(DELAY_DEPTH);
    localparam int SMP_W       = 16;
    localparam int GAIN_W      = 17;
    localparam int OPA_W       = 18;
    localparam int OPB_W       = 18;
    localparam int PROD_W      = OPA_W + OPB_W;
    localparam int ACC_W       = PROD_W + 1;
    localparam int STEP_W      = 5;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);

    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_DELAY = 2'd1;
    localparam logic [1:0] CFG_DECAY = 2'd2;
    localparam logic [1:0] CFG_WET   = 2'd3;

    localparam logic              RST_MODE  = 1'b1;
    localparam logic [GAIN_W-1:0] RST_DELAY = GAIN_W'(24000);
    localparam logic [GAIN_W-1:0] RST_DECAY = GAIN_W'(19661);
    localparam logic [GAIN_W-1:0] RST_WET   = GAIN_W'(32768);

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [STEP_W-1:0] t_step;

    typedef struct packed {
        logic signed [SMP_W-1:0] left_in;
        logic signed [SMP_W-1:0] right_in;
        logic                    frame_last;
    } t_in_beat;

    typedef struct packed {
        logic signed [SMP_W-1:0] left_out;
        logic signed [SMP_W-1:0] right_out;
        logic                    frame_end;
    } t_out_beat;

    typedef struct packed {
        logic              mode;
        logic [GAIN_W-1:0] delay;
        logic [GAIN_W-1:0] decay;
        logic [GAIN_W-1:0] wet;
    } t_cfg;

    typedef enum logic [3:0] {
        A_LS, A_RS, A_M, A_DDRY, A_DWET, A_INL, A_INR, A_INSUM, A_INL2
    } t_asel;

    typedef enum logic [1:0] {
        B_DECAY, B_WET, B_DRY, B_ONE
    } t_bsel;

    typedef enum logic [1:0] {
        ACC_HOLD, ACC_LOAD, ACC_ADD
    } t_accop;

    typedef enum logic [2:0] {
        DST_NONE, DST_M, DST_DDRY, DST_DWET, DST_OUTL, DST_OUTR, DST_ADDL, DST_ADDR
    } t_dst;

    typedef enum logic [1:0] {
        SEQ_CLEAR, SEQ_IDLE, SEQ_RUN
    } t_seq_state;

    typedef struct packed {
        t_asel  asel;
        t_bsel  bsel;
        t_accop acc_op;
        logic   rnd17;
        t_dst   dst;
        logic   br_mono;
        t_step  target;
        logic   done;
        logic   wr_right;
    } t_ctrl;

    typedef struct packed {
        t_asel  asel;
        t_bsel  bsel;
        t_accop acc_op;
        logic   rnd17;
        t_dst   dst;
        logic   commit;
        logic   wr_right;
        logic   clr_we;
        t_addr  clr_addr;
    } t_dp_cmd;

endpackage

### sv/fde_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fde_seq
// Microcode sequencer: step counter, control ROM, mode branch, store clearing.
// ----------------------------------------------------------------------------
module fde_seq
    import fde_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_mono,
    input  logic    i_out_free,
    output logic    o_ready,
    output t_dp_cmd o_cmd
);

    localparam t_step ST_MONO = t_step'(14);

    localparam t_ctrl UC_NOP = '{
        asel: A_LS, bsel: B_DECAY, acc_op: ACC_HOLD, rnd17: 1'b0, dst: DST_NONE,
        br_mono: 1'b0, target: '0, done: 1'b0, wr_right: 1'b0
    };

    function automatic t_ctrl uc_rom(input t_step s);
        t_ctrl c;
        c = UC_NOP;
        case (s)
            t_step'(0):  begin c.br_mono = 1'b1; c.target = ST_MONO; end
            // stereo
            t_step'(1):  begin c.asel = A_RS;    c.bsel = B_WET; end
            t_step'(2):  begin c.asel = A_LS;    c.bsel = B_DRY;   c.acc_op = ACC_LOAD; end
            t_step'(3):  begin c.asel = A_RS;    c.bsel = B_DECAY; c.acc_op = ACC_ADD; end
            t_step'(4):  begin
                c.asel = A_LS; c.bsel = B_DECAY; c.acc_op = ACC_LOAD; c.dst = DST_M;
            end
            t_step'(5):  begin
                c.asel = A_M; c.bsel = B_DECAY; c.acc_op = ACC_LOAD; c.dst = DST_DDRY;
            end
            t_step'(6):  begin
                c.asel = A_INL2; c.bsel = B_DRY; c.acc_op = ACC_LOAD; c.dst = DST_DWET;
            end
            t_step'(7):  begin
                c.asel = A_INSUM; c.bsel = B_WET; c.acc_op = ACC_LOAD; c.dst = DST_OUTL;
            end
            t_step'(8):  begin c.asel = A_DDRY;  c.bsel = B_DRY;   c.acc_op = ACC_ADD; end
            t_step'(9):  begin
                c.asel = A_DWET; c.bsel = B_WET; c.acc_op = ACC_LOAD;
                c.rnd17 = 1'b1; c.dst = DST_ADDL;
            end
            t_step'(10): begin c.asel = A_INR;   c.bsel = B_DRY;   c.acc_op = ACC_ADD; end
            t_step'(11): begin c.acc_op = ACC_LOAD; c.dst = DST_OUTR; end
            t_step'(12): begin c.dst = DST_ADDR; end
            t_step'(13): begin c.done = 1'b1; c.wr_right = 1'b1; end
            // mono
            t_step'(14): begin c.asel = A_LS;    c.bsel = B_DECAY; end
            t_step'(15): begin c.asel = A_INL;   c.bsel = B_ONE;   c.acc_op = ACC_LOAD; end
            t_step'(16): begin c.acc_op = ACC_LOAD; c.dst = DST_OUTL; end
            t_step'(17): begin c.dst = DST_ADDL; end
            t_step'(18): begin c.done = 1'b1; end
            default:     begin c.done = 1'b1; end
        endcase
        return c;
    endfunction

    t_seq_state r_state, n_state;
    t_step      r_step, n_step;
    t_addr      r_clr, n_clr;
    t_ctrl      cw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_CLEAR;
            r_step  <= '0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_clr   <= n_clr;
        end
    end

    always_comb begin
        cw      = uc_rom(r_step);
        n_state = r_state;
        n_step  = r_step;
        n_clr   = r_clr;
        o_cmd   = '{
            asel: A_LS, bsel: B_DECAY, acc_op: ACC_HOLD, rnd17: 1'b0, dst: DST_NONE,
            commit: 1'b0, wr_right: 1'b0, clr_we: 1'b0, clr_addr: r_clr
        };
        case (r_state)
            SEQ_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (r_clr == t_addr'(DELAY_DEPTH - 1)) begin
                    n_state = SEQ_IDLE;
                end else begin
                    n_clr = r_clr + t_addr'(1);
                end
            end
            SEQ_IDLE: begin
                if (i_start) begin
                    n_state = SEQ_RUN;
                    n_step  = '0;
                end
            end
            SEQ_RUN: begin
                o_cmd.asel = cw.asel;
                o_cmd.bsel = cw.bsel;
                if (cw.done) begin
                    if (i_out_free) begin
                        o_cmd.commit   = 1'b1;
                        o_cmd.wr_right = cw.wr_right;
                        n_state        = SEQ_IDLE;
                    end
                end else begin
                    o_cmd.acc_op = cw.acc_op;
                    o_cmd.rnd17  = cw.rnd17;
                    o_cmd.dst    = cw.dst;
                    n_step = (cw.br_mono && i_mono) ? cw.target : r_step + t_step'(1);
                end
            end
            default: begin
                n_state = SEQ_CLEAR;
            end
        endcase
    end

    assign o_ready = (r_state == SEQ_IDLE);

endmodule

### sv/fde_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fde_dp
// Datapath: delay stores, write pointer, shared multiplier, accumulator,
// round/saturate stage and scratch registers.
// ----------------------------------------------------------------------------
module fde_dp
    import fde_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    input  t_cfg                    i_cfg,
    input  t_in_beat                i_in,
    output logic signed [SMP_W-1:0] o_outl,
    output logic signed [SMP_W-1:0] o_outr
);

    function automatic logic signed [SMP_W-1:0] sat16(input logic signed [ACC_W-1:0] x);
        if (x > ACC_W'(32767)) begin
            return SMP_W'(32767);
        end else if (x < -ACC_W'(32768)) begin
            return SMP_W'(-32768);
        end
        return x[SMP_W-1:0];
    endfunction

    logic signed [SMP_W-1:0] r_lmem [DELAY_DEPTH];
    logic signed [SMP_W-1:0] r_rmem [DELAY_DEPTH];
    logic signed [SMP_W-1:0] r_ls, r_rs;
    t_addr                   r_wp;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [SMP_W-1:0]  r_m, r_ddry, r_dwet, r_outl, r_outr, r_addl, r_addr;

    logic [GAIN_W-1:0]        decay, wet, dry, gain;
    logic [ADDR_W:0]          dly, rd_sum;
    t_addr                    rd_addr, wr_addr;
    logic signed [OPA_W-1:0]  opa;
    logic signed [OPB_W-1:0]  opb;
    logic signed [ACC_W-1:0]  rsum, rsh;
    logic signed [SMP_W-1:0]  rval, lwr, rwr;
    logic signed [SMP_W-1:0]  lwd, rwd;

    always_comb begin
        decay = (i_cfg.decay > GAIN_ONE) ? GAIN_ONE : i_cfg.decay;
        wet   = (i_cfg.wet > GAIN_ONE) ? GAIN_ONE : i_cfg.wet;
        dry   = GAIN_ONE - wet;

        if (i_cfg.delay == '0) begin
            dly = (ADDR_W + 1)'(1);
        end else if (32'(i_cfg.delay) > 32'(DELAY_DEPTH - 1)) begin
            dly = (ADDR_W + 1)'(DELAY_DEPTH - 1);
        end else begin
            dly = (ADDR_W + 1)'(i_cfg.delay);
        end
        if ({1'b0, r_wp} >= dly) begin
            rd_sum = {1'b0, r_wp} - dly;
        end else begin
            rd_sum = {1'b0, r_wp} + (ADDR_W + 1)'(DELAY_DEPTH) - dly;
        end
        rd_addr = rd_sum[ADDR_W-1:0];

        case (i_cmd.asel)
            A_LS:    opa = OPA_W'(r_ls);
            A_RS:    opa = OPA_W'(r_rs);
            A_M:     opa = OPA_W'(r_m);
            A_DDRY:  opa = OPA_W'(r_ddry);
            A_DWET:  opa = OPA_W'(r_dwet);
            A_INL:   opa = OPA_W'(i_in.left_in);
            A_INR:   opa = OPA_W'(i_in.right_in);
            A_INSUM: opa = OPA_W'(i_in.left_in) + OPA_W'(i_in.right_in);
            A_INL2:  opa = OPA_W'(i_in.left_in) <<< 1;
            default: opa = '0;
        endcase

        case (i_cmd.bsel)
            B_DECAY: gain = decay;
            B_WET:   gain = wet;
            B_DRY:   gain = dry;
            B_ONE:   gain = GAIN_ONE;
            default: gain = '0;
        endcase
        opb = $signed({1'b0, gain});

        if (i_cmd.rnd17) begin
            rsum = r_acc + ACC_W'(65536);
            rsh  = rsum >>> 17;
        end else begin
            rsum = r_acc + ACC_W'(32768);
            rsh  = rsum >>> 16;
        end
        rval = sat16(rsh);

        lwr = sat16(ACC_W'(r_outl) + ACC_W'(r_addl));
        rwr = sat16(ACC_W'(r_addr) + ACC_W'(r_outr));

        wr_addr = i_cmd.clr_we ? i_cmd.clr_addr : r_wp;
        lwd     = i_cmd.clr_we ? '0 : lwr;
        rwd     = i_cmd.clr_we ? '0 : rwr;
    end

    // delay stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_we || i_cmd.commit) begin
            r_lmem[wr_addr] <= lwd;
        end
        r_ls <= r_lmem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_we || (i_cmd.commit && i_cmd.wr_right)) begin
            r_rmem[wr_addr] <= rwd;
        end
        r_rs <= r_rmem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
        end else if (i_cmd.commit) begin
            r_wp <= (r_wp == t_addr'(DELAY_DEPTH - 1)) ? '0 : r_wp + t_addr'(1);
        end
    end

    // MAC and scratch registers
    always_ff @(posedge i_clk) begin
        r_prod <= opa * opb;
        case (i_cmd.acc_op)
            ACC_LOAD: r_acc <= ACC_W'(r_prod);
            ACC_ADD:  r_acc <= r_acc + ACC_W'(r_prod);
            default:  r_acc <= r_acc;
        endcase
        case (i_cmd.dst)
            DST_M:    r_m    <= rval;
            DST_DDRY: r_ddry <= rval;
            DST_DWET: r_dwet <= rval;
            DST_OUTL: r_outl <= rval;
            DST_OUTR: r_outr <= rval;
            DST_ADDL: r_addl <= rval;
            DST_ADDR: r_addr <= rval;
            default:  ;
        endcase
    end

    assign o_outl = r_outl;
    assign o_outr = r_outr;

endmodule

### sv/feedback_delay_echo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feedback_delay_echo
// Feedback echo over two circular sample stores, mono or stereo cross-fed.
// ----------------------------------------------------------------------------
// After reset both 131072-entry stores are zeroed by a clearing pass, during
// which no input beat is accepted (register writes are). Each frame then runs
// as a short microprogram on one shared 18x18 multiplier with an accumulator,
// one multiply per cycle. The result sits in an output register, and the next
// frame is accepted while it waits; a frame only stalls at its final step if
// the previous result has still not been taken. The user must write registers
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module feedback_delay_echo
    import fde_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_beat          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_beat         o_out_data,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [GAIN_W-1:0] i_cfg_data
);

    t_cfg      r_cfg;
    t_in_beat  r_in;
    t_out_beat r_out;
    logic      r_out_valid;

    t_dp_cmd                 cmd;
    logic                    in_acc, out_free;
    logic signed [SMP_W-1:0] outl, outr;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode  <= RST_MODE;
            r_cfg.delay <= RST_DELAY;
            r_cfg.decay <= RST_DECAY;
            r_cfg.wet   <= RST_WET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:  r_cfg.mode  <= i_cfg_data[0];
                CFG_DELAY: r_cfg.delay <= i_cfg_data;
                CFG_DECAY: r_cfg.decay <= i_cfg_data;
                CFG_WET:   r_cfg.wet   <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
        end
        if (cmd.commit) begin
            r_out.left_out  <= outl;
            r_out.right_out <= r_cfg.mode ? outr : '0;
            r_out.frame_end <= r_in.frame_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    fde_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_acc),
        .i_mono     (!r_cfg.mode),
        .i_out_free (out_free),
        .o_ready    (o_in_ready),
        .o_cmd      (cmd)
    );

    fde_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_cfg   (r_cfg),
        .i_in    (r_in),
        .o_outl  (outl),
        .o_outr  (outr)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
